/* src/hbmr_pkg.sv */
// Package for the histogram block matcher: shared types, constants and sequencer states.
// No dependencies.
package hbmr_pkg;

  localparam int SQ_W       = 40;
  localparam int ROOT_W     = SQ_W / 2;
  localparam int OFS_W      = 6;
  localparam int BIN_W      = 16;
  localparam int SCORE_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int DVD_W      = ROOT_W + FRAC_W;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = DVD_W;
  localparam int REM_W      = ROOT_W + 4;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam logic [SQ_W-1:0] SQ_MAX = {SQ_W{1'b1}};

  typedef enum logic [2:0] {
    F_IDLE,
    F_ROOT1,
    F_ROOT2,
    F_DIFF,
    F_DIV,
    F_DONE
  } fin_state_t;

  typedef struct packed {
    logic              start;
    logic [SQ_W-1:0]   best_sq;
    logic [SQ_W-1:0]   second_sq;
    logic [OFS_W-1:0]  dx;
    logic [OFS_W-1:0]  dy;
  } hbmr_start_t;

endpackage

/* src/hbmr_in_if.sv */
// Input channel: one bin pair request with candidate offset and end marks.
// Stand-alone interface, no dependencies.
interface hbmr_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        ref_bin;
  logic [15:0]        cand_bin;
  logic signed [5:0]  offset_x;
  logic signed [5:0]  offset_y;
  logic               last_bin;
  logic               last_candidate;

  modport source (output valid, ref_bin, cand_bin, offset_x, offset_y, last_bin,
                  last_candidate, input ready);
  modport sink (input valid, ref_bin, cand_bin, offset_x, offset_y, last_bin,
                last_candidate, output ready);
endinterface

/* src/hbmr_out_if.sv */
// Output channel: best offset and Q16.16 ratio score request.
// Stand-alone interface, no dependencies.
interface hbmr_out_if;
  logic               valid;
  logic               ready;
  logic signed [5:0]  best_x;
  logic signed [5:0]  best_y;
  logic [31:0]        score;

  modport source (output valid, best_x, best_y, score, input ready);
  modport sink (input valid, best_x, best_y, score, output ready);
endinterface

/* src/hbmr_accum.sv */
// Bin accumulator: squares bin differences, sums per candidate, ranks best two.
// Depends on hbmr_pkg and hbmr_in_if.
module hbmr_accum (
  input  logic                 clk,
  input  logic                 rst,
  hbmr_in_if.sink              cand,
  input  logic                 fin_idle,
  output hbmr_pkg::hbmr_start_t start
);
  import hbmr_pkg::*;

  logic                s1_valid;
  logic [2*BIN_W-1:0]  s1_sq;
  logic                s1_last_bin;
  logic                s1_last_cand;
  logic [OFS_W-1:0]    s1_ox;
  logic [OFS_W-1:0]    s1_oy;
  logic                s1_fin;

  logic [SQ_W-1:0]     partial_sum;
  logic [SQ_W-1:0]     best_square;
  logic [SQ_W-1:0]     second_square;
  logic [OFS_W-1:0]    best_dx;
  logic [OFS_W-1:0]    best_dy;

  logic [BIN_W-1:0]    diff;
  logic [SQ_W:0]       sum_wide;
  logic [SQ_W-1:0]     sum;
  logic [SQ_W-1:0]     best_next;
  logic [SQ_W-1:0]     second_next;
  logic [OFS_W-1:0]    dx_next;
  logic [OFS_W-1:0]    dy_next;
  logic                accept;

  assign s1_fin     = s1_valid && s1_last_bin && s1_last_cand;
  assign cand.ready = fin_idle && !s1_fin;
  assign accept     = cand.valid && cand.ready;

  assign diff = (cand.ref_bin > cand.cand_bin) ? (cand.ref_bin - cand.cand_bin)
                                               : (cand.cand_bin - cand.ref_bin);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_sq        <= diff * diff;
      s1_last_bin  <= cand.last_bin;
      s1_last_cand <= cand.last_candidate;
      s1_ox        <= cand.offset_x;
      s1_oy        <= cand.offset_y;
    end
  end

  always_comb begin
    sum_wide    = {1'b0, partial_sum} + {{(SQ_W + 1 - 2*BIN_W){1'b0}}, s1_sq};
    sum         = sum_wide[SQ_W] ? SQ_MAX : sum_wide[SQ_W-1:0];
    best_next   = best_square;
    second_next = second_square;
    dx_next     = best_dx;
    dy_next     = best_dy;
    if (sum < best_square) begin
      second_next = best_square;
      best_next   = sum;
      dx_next     = s1_ox;
      dy_next     = s1_oy;
    end else if (sum < second_square) begin
      second_next = sum;
    end
    start.start     = s1_fin;
    start.best_sq   = best_next;
    start.second_sq = second_next;
    start.dx        = dx_next;
    start.dy        = dy_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_sum   <= '0;
      best_square   <= SQ_MAX;
      second_square <= SQ_MAX;
      best_dx       <= '0;
      best_dy       <= '0;
    end else if (s1_valid) begin
      if (!s1_last_bin) begin
        partial_sum <= sum;
      end else if (s1_last_cand) begin
        partial_sum   <= '0;
        best_square   <= SQ_MAX;
        second_square <= SQ_MAX;
        best_dx       <= '0;
        best_dy       <= '0;
      end else begin
        partial_sum   <= '0;
        best_square   <= best_next;
        second_square <= second_next;
        best_dx       <= dx_next;
        best_dy       <= dy_next;
      end
    end
  end

endmodule

/* src/hbmr_sub.sv */
// Shared subtract and compare unit used by the root, difference and divide steps.
// Depends on hbmr_pkg.
module hbmr_sub (
  input  logic [hbmr_pkg::REM_W-1:0] a,
  input  logic [hbmr_pkg::REM_W-1:0] b,
  output logic [hbmr_pkg::REM_W-1:0] diff,
  output logic                       ge
);
  import hbmr_pkg::*;

  logic [REM_W:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign diff = wide[REM_W-1:0];
  assign ge   = !wide[REM_W];

endmodule

/* src/hbmr_finish.sv */
// Window finisher: two digit-serial square roots and a restoring divide on one
// shared subtractor, then the result register. Depends on hbmr_pkg, hbmr_sub, hbmr_out_if.
module hbmr_finish (
  input  logic                  clk,
  input  logic                  rst,
  input  hbmr_pkg::hbmr_start_t start,
  output logic                  fin_idle,
  hbmr_out_if.source            result
);
  import hbmr_pkg::*;

  fin_state_t         state;
  fin_state_t         state_next;

  logic [SQ_W-1:0]    rad;
  logic [SQ_W-1:0]    second_sq;
  logic [ROOT_W-1:0]  root;
  logic [ROOT_W-1:0]  r1;
  logic [REM_W-1:0]   rem;
  logic [DVD_W-1:0]   dvd;
  logic [DVD_W-1:0]   quo;
  logic [ROOT_W:0]    divisor;
  logic [CNT_W-1:0]   cnt;
  logic [OFS_W-1:0]   dx;
  logic [OFS_W-1:0]   dy;

  logic               res_valid;
  logic [OFS_W-1:0]   res_x;
  logic [OFS_W-1:0]   res_y;
  logic [SCORE_W-1:0] res_score;

  logic [REM_W-1:0]   sub_a;
  logic [REM_W-1:0]   sub_b;
  logic [REM_W-1:0]   sub_diff;
  logic               sub_ge;
  logic               load;

  hbmr_sub u_sub (.a(sub_a), .b(sub_b), .diff(sub_diff), .ge(sub_ge));

  assign fin_idle      = (state == F_IDLE);
  assign result.valid  = res_valid;
  assign result.best_x = res_x;
  assign result.best_y = res_y;
  assign result.score  = res_score;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load       = 1'b0;
    sub_a      = {rem[REM_W-3:0], rad[SQ_W-1:SQ_W-2]};
    sub_b      = {{(REM_W - ROOT_W - 2){1'b0}}, root, 2'b01};
    case (state)
      F_IDLE: begin
        if (start.start) begin
          state_next = F_ROOT1;
        end
      end
      F_ROOT1: begin
        if (cnt == '0) begin
          state_next = F_ROOT2;
        end
      end
      F_ROOT2: begin
        if (cnt == '0) begin
          state_next = F_DIFF;
        end
      end
      F_DIFF: begin
        sub_a      = {{(REM_W - ROOT_W){1'b0}}, root};
        sub_b      = {{(REM_W - ROOT_W){1'b0}}, r1};
        state_next = F_DIV;
      end
      F_DIV: begin
        sub_a = {rem[REM_W-2:0], dvd[DVD_W-1]};
        sub_b = {{(REM_W - ROOT_W - 1){1'b0}}, divisor};
        if (cnt == '0) begin
          state_next = F_DONE;
        end
      end
      F_DONE: begin
        if (!res_valid || result.ready) begin
          load       = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        rad       <= start.best_sq;
        second_sq <= start.second_sq;
        dx        <= start.dx;
        dy        <= start.dy;
        root      <= '0;
        rem       <= '0;
        cnt       <= CNT_W'(ROOT_STEPS - 1);
      end
      F_ROOT1, F_ROOT2: begin
        rad <= {rad[SQ_W-3:0], 2'b00};
        cnt <= cnt - 1'b1;
        if (sub_ge) begin
          rem  <= sub_diff;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= sub_a;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        if (cnt == '0) begin
          rad  <= second_sq;
          rem  <= '0;
          root <= '0;
          cnt  <= CNT_W'(ROOT_STEPS - 1);
          if (state == F_ROOT1) begin
            r1 <= sub_ge ? {root[ROOT_W-2:0], 1'b1} : {root[ROOT_W-2:0], 1'b0};
          end else begin
            root <= sub_ge ? {root[ROOT_W-2:0], 1'b1} : {root[ROOT_W-2:0], 1'b0};
          end
        end
      end
      F_DIFF: begin
        dvd     <= sub_ge ? {sub_diff[ROOT_W-1:0], {FRAC_W{1'b0}}} : '0;
        divisor <= {1'b0, r1} + 1'b1;
        rem     <= '0;
        quo     <= '0;
        cnt     <= CNT_W'(DIV_STEPS - 1);
      end
      F_DIV: begin
        dvd <= {dvd[DVD_W-2:0], 1'b0};
        quo <= {quo[DVD_W-2:0], sub_ge};
        rem <= sub_ge ? sub_diff : sub_a;
        cnt <= cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
    if (load) begin
      res_x     <= dx;
      res_y     <= dy;
      res_score <= (quo[DVD_W-1:SCORE_W] != '0) ? {SCORE_W{1'b1}} : quo[SCORE_W-1:0];
    end
  end

endmodule

/* src/histogram_block_match_ratio.sv */
// Histogram block matcher with ratio test, top level.
// Depends on hbmr_pkg, hbmr_in_if, hbmr_out_if, hbmr_accum, hbmr_finish.
//
// Usage:
//   cand   : one request per bin pair (reference bin, candidate bin, offset,
//            last_bin and last_candidate marks). Bins of a candidate stream
//            one per cycle; last_bin closes a candidate and ranks its distance.
//   result : one request per search window: best offset and Q16.16 score
//            (d2 - d1) / (d1 + 1), saturating.
// Throughput: one bin per cycle within a window. After the last bin of the
//   last candidate, cand.ready stays low while the window is handed over from
//   the accumulator stage, two 20-step square roots, a difference step and a
//   36-step divide run, all on one shared subtractor, and the result register
//   is loaded.
// A pending result waits in its register while the next window streams in;
// if result.ready stays low, the finisher holds and cand.ready stays low
// after the following window ends.
// Reset (rst, synchronous) clears the sums, sets the best/second-best distances
// to all ones and drops result.valid.
module histogram_block_match_ratio (
  input  logic        clk,
  input  logic        rst,
  hbmr_in_if.sink     cand,
  hbmr_out_if.source  result
);
  import hbmr_pkg::*;

  hbmr_start_t start;
  logic        fin_idle;

  hbmr_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .cand     (cand),
    .fin_idle (fin_idle),
    .start    (start)
  );

  hbmr_finish u_finish (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .fin_idle (fin_idle),
    .result   (result)
  );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for histogram_block_match_ratio: streams bin-pair requests, predicts
// each search window's best offset and ratio score, and checks every result.
// Depends on hbmr_pkg, hbmr_in_if, hbmr_out_if and the block itself.
module tb_top;
  import hbmr_pkg::*;

  localparam int NUM_BINS    = 16;
  localparam int SEARCH_SIZE = 65;
  localparam int SETTLE      = 100;

  typedef struct packed {
    logic [BIN_W-1:0]        ref_bin;
    logic [BIN_W-1:0]        cand_bin;
    logic signed [OFS_W-1:0] ofs_x;
    logic signed [OFS_W-1:0] ofs_y;
    logic                    last_bin;
    logic                    last_cand;
  } bin_req_t;

  typedef struct packed {
    logic signed [OFS_W-1:0] best_x;
    logic signed [OFS_W-1:0] best_y;
    logic [SCORE_W-1:0]      score;
  } match_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hbmr_in_if  cand_if ();
  hbmr_out_if res_if ();

  histogram_block_match_ratio u_dut (
    .clk    (clk),
    .rst    (rst),
    .cand   (cand_if),
    .result (res_if)
  );

  always #5 clk = ~clk;

  match_t                  window_results[$];
  longint unsigned         run_sum;
  longint unsigned         top_sq;
  longint unsigned         runner_sq;
  logic signed [OFS_W-1:0] top_dx;
  logic signed [OFS_W-1:0] top_dy;

  bit     idle_en        = 1'b1;
  int     gap_pct        = 20;
  int     rx_hold_cycles = 0;
  int     errors         = 0;
  int     items_sent     = 0;
  match_t got_res;
  match_t want_res;

  task automatic clear_window();
    run_sum   = 0;
    top_sq    = SQ_MAX;
    runner_sq = SQ_MAX;
    top_dx    = '0;
    top_dy    = '0;
  endtask

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  task automatic predict_bin(input bin_req_t r);
    longint unsigned diff, sq, r1, r2, num, q;
    match_t m;
    diff = (r.ref_bin > r.cand_bin) ? r.ref_bin - r.cand_bin : r.cand_bin - r.ref_bin;
    sq = run_sum + diff * diff;
    if (sq > SQ_MAX) sq = SQ_MAX;
    if (!r.last_bin) begin
      run_sum = sq;
    end else begin
      run_sum = 0;
      if (sq < top_sq) begin
        runner_sq = top_sq;
        top_sq    = sq;
        top_dx    = r.ofs_x;
        top_dy    = r.ofs_y;
      end else if (sq < runner_sq) begin
        runner_sq = sq;
      end
      if (r.last_cand) begin
        r1  = floor_root(top_sq);
        r2  = floor_root(runner_sq);
        num = (r2 >= r1) ? (r2 - r1) << FRAC_W : 0;
        q   = num / (r1 + 1);
        if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
        m.best_x = top_dx;
        m.best_y = top_dy;
        m.score  = q[SCORE_W-1:0];
        window_results.push_back(m);
        clear_window();
      end
    end
  endtask

  function automatic bin_req_t mk(input int rb, input int cb, input int ox, input int oy,
                                  input bit lb, input bit lc);
    bin_req_t r;
    r.ref_bin   = BIN_W'(rb);
    r.cand_bin  = BIN_W'(cb);
    r.ofs_x     = OFS_W'(ox);
    r.ofs_y     = OFS_W'(oy);
    r.last_bin  = lb;
    r.last_cand = lc;
    return r;
  endfunction

  function automatic logic [BIN_W-1:0] pick_bin();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return BIN_W'($urandom);
  endfunction

  task automatic send_bin(input bin_req_t r);
    if (idle_en && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      cand_if.valid <= 1'b0;
      {cand_if.ref_bin, cand_if.cand_bin} <= $urandom;
      {cand_if.offset_x, cand_if.offset_y, cand_if.last_bin, cand_if.last_candidate}
        <= 14'($urandom);
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    cand_if.valid          <= 1'b1;
    cand_if.ref_bin        <= r.ref_bin;
    cand_if.cand_bin       <= r.cand_bin;
    cand_if.offset_x       <= r.ofs_x;
    cand_if.offset_y       <= r.ofs_y;
    cand_if.last_bin       <= r.last_bin;
    cand_if.last_candidate <= r.last_cand;
    do @(posedge clk); while (!cand_if.ready);
    predict_bin(r);
    items_sent++;
  endtask

  task automatic wait_drained();
    cand_if.valid <= 1'b0;
    while (window_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // one search window against a fixed reference histogram
  task automatic send_window(input int n_cand, input int max_bins, input bit stray);
    logic [BIN_W-1:0]        ref_hist[64];
    logic [BIN_W-1:0]        prev_hist[64];
    logic [BIN_W-1:0]        cb;
    logic signed [OFS_W-1:0] ox, oy;
    int nb, prev_nb, mode, delta;
    bin_req_t r;
    prev_nb = 0;
    for (int i = 0; i < 64; i++) begin
      ref_hist[i]  = pick_bin();
      prev_hist[i] = '0;
    end
    for (int c = 0; c < n_cand; c++) begin
      mode = $urandom_range(0, 9);
      if (mode == 0 && prev_nb == 0) mode = 9;
      nb = (mode == 0) ? prev_nb : $urandom_range(1, max_bins);
      ox = OFS_W'($urandom);
      oy = OFS_W'($urandom);
      for (int b = 0; b < nb; b++) begin
        if (mode == 0) begin
          cb = prev_hist[b];
        end else if (mode <= 4) begin
          delta = $urandom_range(0, 300);
          if ($urandom_range(0, 1))
            cb = (int'(ref_hist[b]) + delta > 65535) ? '1 : BIN_W'(int'(ref_hist[b]) + delta);
          else
            cb = (int'(ref_hist[b]) < delta) ? '0 : BIN_W'(int'(ref_hist[b]) - delta);
        end else if (mode == 5) begin
          cb = ref_hist[b];
        end else begin
          cb = pick_bin();
        end
        prev_hist[b] = cb;
        r.ref_bin  = ref_hist[b];
        r.cand_bin = cb;
        r.last_bin = (b == nb - 1);
        if (r.last_bin) begin
          r.ofs_x     = ox;
          r.ofs_y     = oy;
          r.last_cand = (c == n_cand - 1);
        end else begin
          r.ofs_x     = OFS_W'($urandom);
          r.ofs_y     = OFS_W'($urandom);
          r.last_cand = stray && ($urandom_range(0, 3) == 0);
        end
        send_bin(r);
      end
      prev_nb = nb;
    end
  endtask

  task automatic test_extremes();
    send_bin(mk(0, 65535, -32, 31, 1, 0));
    send_bin(mk(65535, 65535, 31, -32, 1, 0));
    send_bin(mk(0, 0, 0, 0, 0, 0));
    send_bin(mk(65535, 0, -1, 1, 1, 1));
  endtask

  // equal distances: the earlier candidate keeps the best slot
  task automatic test_ties();
    send_bin(mk(1000, 1100, 0, 0, 0, 0));
    send_bin(mk(500, 400, 5, 6, 1, 0));
    send_bin(mk(2000, 1900, 0, 0, 0, 0));
    send_bin(mk(800, 900, 7, 8, 1, 0));
    send_bin(mk(10, 60000, -7, -8, 1, 1));
  endtask

  task automatic test_stray_mark();
    send_bin(mk(10, 20, 3, 3, 0, 1));
    send_bin(mk(30, 45, -4, 4, 0, 1));
    send_bin(mk(1, 2, 3, 4, 1, 0));
    send_bin(mk(7, 7, -5, 9, 1, 1));
  endtask

  task automatic test_single_window();
    send_bin(mk(100, 103, 11, -12, 1, 1));
    send_bin(mk(65535, 0, -20, 20, 1, 1));
  endtask

  // distance clips to all ones and never ranks
  task automatic test_saturation();
    for (int i = 0; i < 260; i++) send_bin(mk(0, 65535, 9, 9, i == 259, 1'b0));
    send_bin(mk(100, 90, -3, 2, 1, 1));
    for (int i = 0; i < 260; i++) send_bin(mk(65535, 0, 13, -13, i == 259, i == 259));
  endtask

  task automatic test_backpressure();
    rx_hold_cycles = 500;
    for (int w = 0; w < 5; w++) send_window(2, 2, 1'b0);
  endtask

  task automatic test_drain();
    send_window(3, NUM_BINS, 1'b1);
    wait_drained();
    send_window(2, 4, 1'b0);
  endtask

  task automatic test_random(input int target);
    int first, sel, nc, mb;
    first = items_sent;
    while (items_sent - first < target) begin
      if (items_sent - first > target * 85 / 100) idle_en = 1'b0;
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
        nc = $urandom_range(20, SEARCH_SIZE);
        mb = 3;
      end else if (sel < 9) begin
        nc = $urandom_range(1, 3);
        mb = 64;
      end else begin
        nc = $urandom_range(1, 4);
        mb = NUM_BINS;
      end
      gap_pct = ($urandom_range(0, 4) == 0) ? 0 : 20;
      send_window(nc, mb, 1'($urandom_range(0, 1)));
    end
  endtask

  // result side: random stalls, plus a long hold on request
  initial begin
    res_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        res_if.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        res_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      got_res.best_x = res_if.best_x;
      got_res.best_y = res_if.best_y;
      got_res.score  = res_if.score;
      if (window_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result x=%0d y=%0d score=%h", $time,
                 got_res.best_x, got_res.best_y, got_res.score);
      end else begin
        want_res = window_results.pop_front();
        if (got_res.best_x !== want_res.best_x || got_res.best_y !== want_res.best_y ||
            got_res.score !== want_res.score) begin
          errors++;
          $display("%0t: mismatch expected x=%0d y=%0d score=%h actual x=%0d y=%0d score=%h",
                   $time, want_res.best_x, want_res.best_y, want_res.score,
                   got_res.best_x, got_res.best_y, got_res.score);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("histogram_block_match_ratio verification failed");
    $finish;
  end

  initial begin
    cand_if.valid          <= 1'b0;
    cand_if.ref_bin        <= '0;
    cand_if.cand_bin       <= '0;
    cand_if.offset_x       <= '0;
    cand_if.offset_y       <= '0;
    cand_if.last_bin       <= 1'b0;
    cand_if.last_candidate <= 1'b0;
    clear_window();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_ties();
    test_stray_mark();
    test_single_window();
    test_saturation();
    test_backpressure();
    test_drain();
    test_random(920);
    wait_drained();
    if (errors == 0) begin
      $display("histogram_block_match_ratio verification clean");
    end else begin
      $display("histogram_block_match_ratio verification failed");
    end
    $finish;
  end

endmodule
